FILE: rtl/core/dpbh_pkg.sv
package dpbh_pkg;

  // Pixel coordinate widths.
  localparam int COL_BITS = 12;
  localparam int ROW_BITS = 12;

  // Each axis has its own projection unit, both sized for the wider coordinate.
  localparam int AXIS_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;

  // Fixed field widths.
  localparam int DEPTH_W  = 16;
  localparam int INV_W    = 24;
  localparam int CENTER_W = 16;
  localparam int COORD_W  = 18;
  localparam int WRIST_W  = 3 * COORD_W;
  localparam int RADIUS_W = 16;
  localparam int HAND_W   = 2;

  // The offset magnitude must hold both a shifted pixel and a full centre value.
  localparam int MAG_W   = (AXIS_BITS + 4 > CENTER_W) ? AXIS_BITS + 4 : CENTER_W;
  localparam int OFF_W   = MAG_W + 1;
  localparam int PD_W    = MAG_W + DEPTH_W;
  localparam int PQ_W    = PD_W + INV_W;
  localparam int FRAC_W  = 28;
  localparam int RND_W   = PQ_W + 1;
  localparam int R_W     = RND_W - FRAC_W;

  // Saturation limits for the 18-bit signed coordinates.
  localparam logic [R_W-1:0] SAT_POS = R_W'(131071);
  localparam logic [R_W-1:0] SAT_NEG = R_W'(131072);

  // Pipeline depth split.
  localparam int PROJ_STAGES  = 4;
  localparam int LABEL_STAGES = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = WRIST_W;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST_LH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST_RH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HAND_RADIUS = 3'd6;

  // Hand label codes.
  localparam logic [HAND_W-1:0] HAND_NONE  = 2'd0;
  localparam logic [HAND_W-1:0] HAND_LEFT  = 2'd1;
  localparam logic [HAND_W-1:0] HAND_RIGHT = 2'd2;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [WRIST_W-1:0]  wrist_lh;
    logic [WRIST_W-1:0]  wrist_rh;
    logic [RADIUS_W-1:0] hand_radius;
  } cfg_t;

endpackage

FILE: rtl/core/depth_pixel_backproject_hand_label.sv
// Back-projects hand pixels of a depth image into camera-frame points in
// millimetres and labels each point left, right or no hand by its distance to
// the two configured wrists. A pixel word is taken every clock while in_stall is
// low; a pixel with a zero mask or zero depth is dropped and yields no output
// word, and all other pixels come out in arrival order through a six-stage
// pipeline (offset, two chained multiplies per axis, round and saturate, squared
// distances, compare) whose stages each hold one pixel. Bubbles close up under
// output stall, so the input stalls only when every stage is full. Configuration
// writes are always ready and must be made while the pipeline is empty.
module depth_pixel_backproject_hand_label (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dpbh_pkg::COL_BITS-1:0]       col,
  input  logic [dpbh_pkg::ROW_BITS-1:0]       row,
  input  logic [7:0]                          hand_mask,
  input  logic [dpbh_pkg::DEPTH_W-1:0]        depth_mm,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dpbh_pkg::COORD_W-1:0] x_mm,
  output logic signed [dpbh_pkg::COORD_W-1:0] y_mm,
  output logic [dpbh_pkg::DEPTH_W-1:0]        z_mm,
  output logic [dpbh_pkg::HAND_W-1:0]         hand,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpbh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpbh_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dpbh_pkg::*;

  localparam int STAGES = PROJ_STAGES + LABEL_STAGES;

  cfg_t cfg;
  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] en;
  logic [DEPTH_W-1:0] z0, z1, z2, z3;
  logic signed [COORD_W-1:0] x3, y3;

  assign cfg_ready = 1'b1;

  dpbh_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid[STAGES-1];

  // Valid bits; pixels that give no point enter as bubbles.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid && (hand_mask != 8'd0) && (depth_mm != '0);
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Depth travels alongside the projection stages.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      z0 <= depth_mm;
    end
    if (en[1]) begin
      z1 <= z0;
    end
    if (en[2]) begin
      z2 <= z1;
    end
    if (en[3]) begin
      z3 <= z2;
    end
  end

  dpbh_project u_proj_x (
    .clk    (clk),
    .en     (en[PROJ_STAGES-1:0]),
    .pix    (AXIS_BITS'(col)),
    .center (cfg.center_x),
    .inv    (cfg.inv_focal_x),
    .depth  (z0),
    .coord  (x3)
  );

  dpbh_project u_proj_y (
    .clk    (clk),
    .en     (en[PROJ_STAGES-1:0]),
    .pix    (AXIS_BITS'(row)),
    .center (cfg.center_y),
    .inv    (cfg.inv_focal_y),
    .depth  (z0),
    .coord  (y3)
  );

  dpbh_label u_label (
    .clk         (clk),
    .en          (en[STAGES-1:PROJ_STAGES]),
    .x_in        (x3),
    .y_in        (y3),
    .z_in        (z3),
    .wrist_lh    (cfg.wrist_lh),
    .wrist_rh    (cfg.wrist_rh),
    .hand_radius (cfg.hand_radius),
    .x_mm        (x_mm),
    .y_mm        (y_mm),
    .z_mm        (z_mm),
    .hand        (hand)
  );

endmodule

FILE: rtl/core/dpbh_cfg.sv
module dpbh_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [dpbh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpbh_pkg::CFG_DATA_W-1:0] cfg_data,
  output dpbh_pkg::cfg_t                  cfg
);
  import dpbh_pkg::*;

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_focal_x <= INV_W'(31957);
      cfg.inv_focal_y <= INV_W'(31957);
      cfg.center_x    <= CENTER_W'(5120);
      cfg.center_y    <= CENTER_W'(3840);
      cfg.wrist_lh    <= '0;
      cfg.wrist_rh    <= '0;
      cfg.hand_radius <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INV_FOCAL_X: cfg.inv_focal_x <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y: cfg.inv_focal_y <= cfg_data[INV_W-1:0];
        REG_CENTER_X:    cfg.center_x    <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:    cfg.center_y    <= cfg_data[CENTER_W-1:0];
        REG_WRIST_LH:    cfg.wrist_lh    <= cfg_data[WRIST_W-1:0];
        REG_WRIST_RH:    cfg.wrist_rh    <= cfg_data[WRIST_W-1:0];
        REG_HAND_RADIUS: cfg.hand_radius <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/dpbh_project.sv
module dpbh_project (
  input  logic                                clk,
  input  logic [dpbh_pkg::PROJ_STAGES-1:0]    en,
  input  logic [dpbh_pkg::AXIS_BITS-1:0]      pix,
  input  logic [dpbh_pkg::CENTER_W-1:0]       center,
  input  logic [dpbh_pkg::INV_W-1:0]          inv,
  input  logic [dpbh_pkg::DEPTH_W-1:0]        depth,
  output logic signed [dpbh_pkg::COORD_W-1:0] coord
);
  import dpbh_pkg::*;

  localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (FRAC_W - 1);

  logic [OFF_W-1:0] off;
  logic             neg0, neg1, neg2;
  logic [MAG_W-1:0] mag0;
  logic [PD_W-1:0]  prod1;
  logic [PQ_W-1:0]  prod2;
  logic [RND_W-1:0] rnd;
  logic [R_W-1:0]   mag_r;
  logic [COORD_W-1:0] coord_next;

  // Signed Q.4 offset of the pixel from the principal point.
  always_comb begin
    off = OFF_W'({pix, 4'b0000}) - OFF_W'(center);
  end

  // Stage 0: sign and magnitude of the offset.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0 <= off[OFF_W-1];
      mag0 <= off[OFF_W-1] ? MAG_W'(-off) : MAG_W'(off);
    end
  end

  // Stage 1: magnitude times depth. The depth word is the one in stage 0.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg1  <= neg0;
      prod1 <= PD_W'(mag0) * PD_W'(depth);
    end
  end

  // Stage 2: times the reciprocal focal length, 28 fraction bits.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg2  <= neg1;
      prod2 <= PQ_W'(prod1) * PQ_W'(inv);
    end
  end

  // Round halves away from zero on the magnitude, then saturate and apply the sign.
  always_comb begin
    rnd   = RND_W'(prod2) + ROUND_HALF;
    mag_r = rnd[RND_W-1:FRAC_W];
    if (neg2) begin
      if (mag_r > SAT_NEG) begin
        coord_next = COORD_W'(SAT_NEG);
      end else begin
        coord_next = COORD_W'(-mag_r);
      end
    end else begin
      if (mag_r > SAT_POS) begin
        coord_next = COORD_W'(SAT_POS);
      end else begin
        coord_next = mag_r[COORD_W-1:0];
      end
    end
  end

  // Stage 3: finished coordinate.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      coord <= $signed(coord_next);
    end
  end

endmodule

FILE: rtl/core/dpbh_label.sv
module dpbh_label (
  input  logic                                clk,
  input  logic [dpbh_pkg::LABEL_STAGES-1:0]   en,
  input  logic signed [dpbh_pkg::COORD_W-1:0] x_in,
  input  logic signed [dpbh_pkg::COORD_W-1:0] y_in,
  input  logic [dpbh_pkg::DEPTH_W-1:0]        z_in,
  input  logic [dpbh_pkg::WRIST_W-1:0]        wrist_lh,
  input  logic [dpbh_pkg::WRIST_W-1:0]        wrist_rh,
  input  logic [dpbh_pkg::RADIUS_W-1:0]       hand_radius,
  output logic signed [dpbh_pkg::COORD_W-1:0] x_mm,
  output logic signed [dpbh_pkg::COORD_W-1:0] y_mm,
  output logic [dpbh_pkg::DEPTH_W-1:0]        z_mm,
  output logic [dpbh_pkg::HAND_W-1:0]         hand
);
  import dpbh_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int R2_W   = 2 * RADIUS_W;

  // Square of a 19-bit signed difference; the result always fits in 36 bits.
  function automatic logic [SQ_W-1:0] square(input logic signed [DIFF_W-1:0] d);
    logic signed [2*DIFF_W-1:0] de;
    logic signed [2*DIFF_W-1:0] p;
    de = (2*DIFF_W)'(d);
    p  = de * de;
    return p[SQ_W-1:0];
  endfunction

  // Difference of a point coordinate and a signed 18-bit wrist field.
  function automatic logic signed [DIFF_W-1:0] diff(
    input logic signed [DIFF_W-1:0] a,
    input logic [COORD_W-1:0]       w
  );
    logic signed [DIFF_W-1:0] we;
    we = DIFF_W'($signed(w));
    return a - we;
  endfunction

  logic signed [DIFF_W-1:0] xe, ye, ze;
  logic [SQ_W-1:0] lx, ly, lz, rx, ry, rz;
  logic [R2_W-1:0] r2;
  logic signed [COORD_W-1:0] x4, y4;
  logic [DEPTH_W-1:0] z4;
  logic [SUM_W-1:0] dl, dr;
  logic in_l, in_r;
  logic [HAND_W-1:0] hand_next;

  always_comb begin
    xe = DIFF_W'(x_in);
    ye = DIFF_W'(y_in);
    ze = $signed(DIFF_W'(z_in));
  end

  // Stage 4: squared axis distances to both wrists and the squared radius.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      lx <= square(diff(xe, wrist_lh[COORD_W-1:0]));
      ly <= square(diff(ye, wrist_lh[2*COORD_W-1:COORD_W]));
      lz <= square(diff(ze, wrist_lh[3*COORD_W-1:2*COORD_W]));
      rx <= square(diff(xe, wrist_rh[COORD_W-1:0]));
      ry <= square(diff(ye, wrist_rh[2*COORD_W-1:COORD_W]));
      rz <= square(diff(ze, wrist_rh[3*COORD_W-1:2*COORD_W]));
      r2 <= R2_W'(hand_radius) * R2_W'(hand_radius);
      x4 <= x_in;
      y4 <= y_in;
      z4 <= z_in;
    end
  end

  // Sum the squares and pick the wrist; the strictly nearer one wins, ties go right.
  always_comb begin
    dl   = SUM_W'(lx) + SUM_W'(ly) + SUM_W'(lz);
    dr   = SUM_W'(rx) + SUM_W'(ry) + SUM_W'(rz);
    in_l = dl < SUM_W'(r2);
    in_r = dr < SUM_W'(r2);
    priority if (in_l && in_r) begin
      hand_next = (dl < dr) ? HAND_LEFT : HAND_RIGHT;
    end else if (in_l) begin
      hand_next = HAND_LEFT;
    end else if (in_r) begin
      hand_next = HAND_RIGHT;
    end else begin
      hand_next = HAND_NONE;
    end
  end

  // Stage 5: output word.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_mm <= x4;
      y_mm <= y4;
      z_mm <= z4;
      hand <= hand_next;
    end
  end

endmodule

FILE: rtl/core/dpbh_checker.sv
module dpbh_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [dpbh_pkg::COORD_W-1:0] x_mm,
  input logic signed [dpbh_pkg::COORD_W-1:0] y_mm,
  input logic [dpbh_pkg::DEPTH_W-1:0]        z_mm,
  input logic [dpbh_pkg::HAND_W-1:0]         hand
);
  import dpbh_pkg::*;

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word withdrawn under stall");

  // A stalled output word does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(x_mm) && $stable(y_mm) && $stable(z_mm)
                               && $stable(hand))
    else $error("output word changed under stall");

  // The input is held off only when the pipeline is blocked at its output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output side is free");

  // Pixels without depth never yield a point, and the label is a defined code.
  a_out_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (z_mm != '0) &&
                  (hand == HAND_NONE || hand == HAND_LEFT || hand == HAND_RIGHT))
    else $error("bad output word");

endmodule

bind depth_pixel_backproject_hand_label dpbh_checker u_dpbh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .x_mm      (x_mm),
  .y_mm      (y_mm),
  .z_mm      (z_mm),
  .hand      (hand)
);
